// File: hw/rtl/sqedt_pkg.sv
package sqedt_pkg;

  localparam int LINE_MAX  = 64;
  localparam int POS_W     = $clog2(LINE_MAX);      // position index
  localparam int CNT_W     = $clog2(LINE_MAX + 1);  // position count
  localparam int BND_AW    = $clog2(LINE_MAX + 1);  // bound store address
  localparam int NUM_W     = 49;                    // |a-b| in Q.8 shifted to Q.24
  localparam int DEN_W     = 23;                    // 2*sp*(q-r)
  localparam int QUO_W     = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [15:0] SPACING_RESET = 16'd256;
  localparam logic [31:0] DIST_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] S_POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] S_NEG_MIN     = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        infinite;
    logic        last;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic             rem_nz;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: hw/rtl/sqedt_front.sv
module sqedt_front import sqedt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item_data,
  input  logic  item_take
);

  item_t             buf_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               wr, rd;

  assign full       = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item_data  = buf_r[rp_r];
  assign wr = push && !full;
  assign rd = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      buf_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/sqedt_div.sv
module sqedt_div import sqedt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic [4:0]         cnt_r;
  logic [DEN_W-1:0]   rem_r;
  logic [DEN_W-1:0]   den_r;
  logic [31:0]        lo_r;
  logic [QUO_W-1:0]   quo_r;
  logic               done_r, ovf_r;
  logic [DEN_W:0]     trial;
  logic               ge;
  logic [NUM_W+6-1:0] den_sh;

  assign trial  = {rem_r, lo_r[31]};
  assign ge     = trial >= {1'b0, den_r};
  // quotient needs more than 32 bits when num >= den * 2^32
  assign den_sh = {den_r[DEN_W-1:0], 32'b0};

  assign rsp.done   = done_r;
  assign rsp.ovf    = ovf_r;
  assign rsp.rem_nz = (rem_r != '0);
  assign rsp.quo    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r  <= req.den;
        rem_r  <= DEN_W'(req.num[NUM_W-1:32]);
        lo_r   <= req.num[31:0];
        quo_r  <= '0;
        cnt_r  <= '0;
        ovf_r  <= ({6'b0, req.num} >= {req.den, 32'b0});
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ovf_r || den_sh == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
          lo_r  <= {lo_r[30:0], 1'b0};
          quo_r <= {quo_r[QUO_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/sqedt_back.sv
module sqedt_back import sqedt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] spacing,
  input  logic        item_valid,
  input  item_t       item_data,
  output logic        item_take,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_dist,
  output logic        out_inf,
  output logic        out_last
);

  typedef enum logic [4:0] {
    S_IDLE, S_AQ1, S_AQ2, S_RDV, S_RDV2, S_B1, S_B2, S_B3, S_DIV, S_FIN,
    S_EADV, S_ECMP, S_EV, S_EV2, S_ED1, S_ED2, S_EOUT
  } state_t;

  state_t state_r;

  logic [31:0]       ss_mem  [0:LINE_MAX-1];
  logic [POS_W-1:0]  vp_mem  [0:LINE_MAX-1];
  logic [31:0]       bnd_mem [0:LINE_MAX];
  logic [31:0]       ss_rd_r, bnd_rd_r;
  logic [POS_W-1:0]  vp_rd_r;
  logic [POS_W-1:0]  ss_ra, vp_ra, vp_wa;
  logic [BND_AW-1:0] bnd_ra, bnd_wa;
  logic              ss_we, vp_we, bnd_we;
  logic [POS_W-1:0]  vp_wd;
  logic [31:0]       bnd_wd;

  logic [CNT_W-1:0]  pos_r, top_r;
  logic [POS_W-1:0]  q_r, r_r, k_r, idx_r, kk_r, v_r;
  logic              last_r;
  logic [31:0]       cur_f_r, f_r, bnd_k_r;
  logic [11:0]       sq_r;
  logic [32:0]       a_r, b_r;
  logic              neg_r;
  logic [31:0]       s_r;
  logic              div_start_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic              ov_r;
  logic [31:0]       od_r;
  logic              oi_r, ol_r;
  logic [31:0]       res_d_r;
  logic              res_i_r;

  logic [15:0]       sp_eff;
  logic [27:0]       sp_sq;
  logic [32:0]       f_plus;
  logic [33:0]       n_diff;
  logic [32:0]       n_mag;
  logic [POS_W-1:0]  qr_diff;
  logic [21:0]       sp_qr;
  logic [DEN_W-1:0]  den_c;
  logic [32:0]       ceil_q;
  logic [31:0]       s_c;
  logic [POS_W-1:0]  dq;
  logic              out_free;
  logic              accept;
  logic              line_end;

  assign sp_eff  = (spacing == 16'd0) ? 16'd1 : spacing;
  assign sp_sq   = sp_eff * sq_r;
  assign n_diff  = {1'b0, a_r} - {1'b0, b_r};
  assign n_mag   = n_diff[33] ? 33'(-n_diff) : n_diff[32:0];
  assign qr_diff = q_r - r_r;
  assign sp_qr   = sp_eff * qr_diff;
  assign den_c   = {sp_qr, 1'b0};
  assign ceil_q  = {1'b0, div_rsp.quo} + {32'b0, div_rsp.rem_nz};
  assign dq      = (q_r >= v_r) ? q_r - v_r : v_r - q_r;
  assign f_plus  = {1'b0, f_r} + {5'b0, sp_sq};

  // floor of the exact quotient, clamped to the signed 32-bit range
  always_comb begin
    if (!neg_r) begin
      s_c = (div_rsp.ovf || div_rsp.quo[31]) ? S_POS_MAX : div_rsp.quo;
    end else begin
      s_c = (div_rsp.ovf || ceil_q > 33'h0_8000_0000) ? S_NEG_MIN : 32'(-ceil_q);
    end
  end

  assign out_free  = !ov_r || pop;
  assign accept    = (state_r == S_IDLE) && item_valid;
  assign item_take = accept;
  assign line_end  = ({1'b0, q_r} + 7'd1) == pos_r;

  assign empty    = !ov_r;
  assign out_dist = od_r;
  assign out_inf  = oi_r;
  assign out_last = ol_r;

  assign div_req.start = div_start_r;
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  // read address selection per state
  always_comb begin
    vp_ra  = k_r;
    ss_ra  = vp_rd_r;
    bnd_ra = BND_AW'(k_r);
    case (state_r)
      S_EADV:  bnd_ra = BND_AW'(idx_r) + 1'b1;
      S_EV:    vp_ra  = idx_r;
      default: ;
    endcase
  end

  // write ports
  always_comb begin
    ss_we  = accept && (pos_r < CNT_W'(LINE_MAX));
    vp_we  = 1'b0;
    vp_wa  = k_r + 1'b1;
    vp_wd  = q_r;
    bnd_we = 1'b0;
    bnd_wa = BND_AW'(k_r) + 1'b1;
    bnd_wd = s_r;
    if (ss_we && !item_data.infinite && top_r == '0) begin
      vp_we = 1'b1;
      vp_wa = '0;
      vp_wd = pos_r[POS_W-1:0];
    end
    if (state_r == S_DIV && div_rsp.done) begin
      if (!(k_r != '0 && $signed(s_c) <= $signed(bnd_k_r))) begin
        vp_we  = 1'b1;
        bnd_we = 1'b1;
        bnd_wd = s_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ss_we) ss_mem[pos_r[POS_W-1:0]] <= item_data.value;
    ss_rd_r <= ss_mem[ss_ra];
  end

  always_ff @(posedge clk) begin
    if (vp_we) vp_mem[vp_wa] <= vp_wd;
    vp_rd_r <= vp_mem[vp_ra];
  end

  always_ff @(posedge clk) begin
    if (bnd_we) bnd_mem[bnd_wa] <= bnd_wd;
    bnd_rd_r <= bnd_mem[bnd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      top_r       <= '0;
      ov_r        <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (pop && ov_r) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r  <= item_data.last;
            cur_f_r <= item_data.value;
            q_r     <= pos_r[POS_W-1:0];
            state_r <= S_FIN;
            if (ss_we) begin
              pos_r <= pos_r + 1'b1;
              if (!item_data.infinite) begin
                if (top_r == '0) begin
                  top_r <= CNT_W'(1);
                end else begin
                  k_r     <= POS_W'(top_r - 1'b1);
                  state_r <= S_AQ1;
                end
              end
            end
          end
        end
        S_AQ1: begin
          sq_r    <= 12'(q_r * q_r);
          state_r <= S_AQ2;
        end
        S_AQ2: begin
          a_r     <= {1'b0, cur_f_r} + {5'b0, sp_sq};
          state_r <= S_RDV;
        end
        S_RDV: state_r <= S_RDV2;
        S_RDV2: begin
          r_r     <= vp_rd_r;
          state_r <= S_B1;
        end
        S_B1: begin
          f_r     <= ss_rd_r;
          bnd_k_r <= bnd_rd_r;
          sq_r    <= 12'(r_r * r_r);
          state_r <= S_B2;
        end
        S_B2: begin
          b_r     <= {1'b0, f_r} + {5'b0, sp_sq};
          state_r <= S_B3;
        end
        S_B3: begin
          neg_r       <= n_diff[33];
          num_r       <= {n_mag, 16'b0};
          den_r       <= den_c;
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done && !div_start_r) begin
            s_r <= s_c;
            if (k_r != '0 && $signed(s_c) <= $signed(bnd_k_r)) begin
              k_r     <= k_r - 1'b1;
              state_r <= S_RDV;
            end else begin
              top_r   <= CNT_W'(k_r) + 2'd2;
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (last_r) begin
            q_r     <= '0;
            idx_r   <= '0;
            kk_r    <= (top_r == '0) ? '0 : POS_W'(top_r - 1'b1);
            state_r <= S_EADV;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EADV: begin
          if (top_r == '0) begin
            res_d_r <= DIST_MAX;
            res_i_r <= 1'b1;
            state_r <= S_EOUT;
          end else if (idx_r < kk_r) begin
            state_r <= S_ECMP;
          end else begin
            state_r <= S_EV;
          end
        end
        S_ECMP: begin
          if ($signed(bnd_rd_r) < $signed({10'b0, q_r, 16'b0})) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_EADV;
          end else begin
            state_r <= S_EV;
          end
        end
        S_EV: state_r <= S_EV2;
        S_EV2: begin
          v_r     <= vp_rd_r;
          state_r <= S_ED1;
        end
        S_ED1: begin
          f_r     <= ss_rd_r;
          sq_r    <= 12'(dq * dq);
          state_r <= S_ED2;
        end
        S_ED2: begin
          res_d_r <= f_plus[32] ? DIST_MAX : f_plus[31:0];
          res_i_r <= 1'b0;
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            od_r <= res_d_r;
            oi_r <= res_i_r;
            ol_r <= line_end;
            if (line_end) begin
              pos_r   <= '0;
              top_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              q_r     <= q_r + 1'b1;
              state_r <= S_EADV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/squared_edt_line_envelope_core.sv
// channel  ports                                              direction
// input    push, full, in_sample_value/infinite, in_line_last  in
// result   empty, pop, out_distance_out/infinite, out_result_last out
// config   psel, penable, pwrite, paddr, pwdata, prdata, pready  APB
//
// a finite sample is tested against envelope vertices one at a time: each
// test fetches the vertex, then runs the 32-step divide, cut short on overflow.
// an infinite sample or the first finite one of a line skips the envelope.
// a line end emits one item per position, advancing through the envelope
// as needed; an all-infinite line emits infinite items; pop can stall output.
// rst_n synchronous; empties the input queue and the line state.
// a 4-entry queue decouples push from the back end; one output register.
module squared_edt_line_envelope_core import sqedt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_sample_value,
  input  logic        in_sample_infinite,
  input  logic        in_line_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_distance_out,
  output logic        out_distance_infinite,
  output logic        out_result_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] spacing_r;
  item_t       in_item, item_data;
  logic        item_valid, item_take;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'b0, spacing_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      spacing_r <= pwdata[15:0];
    end
  end

  assign in_item.value    = in_sample_value;
  assign in_item.infinite = in_sample_infinite;
  assign in_item.last     = in_line_last;

  sqedt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take)
  );

  sqedt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sqedt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .spacing    (spacing_r),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .empty      (empty),
    .pop        (pop),
    .out_dist   (out_distance_out),
    .out_inf    (out_distance_infinite),
    .out_last   (out_result_last)
  );

endmodule
